/* hdl/fir_filter_complex_stream_assert.svh */
// assertion helpers for the complex fir filter
`ifndef FIR_FILTER_COMPLEX_STREAM_ASSERT_SVH
`define FIR_FILTER_COMPLEX_STREAM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FIRCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FIRCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fircs_pkg.sv */
package fircs_pkg;

  localparam int TAP_WIDTH        = 16;
  localparam int OUT_WIDTH        = 38;
  localparam int NUM_TAPS_WIDTH   = 7;
  localparam int TAP_INDEX_WIDTH  = 6;
  localparam int DEF_MAX_TAPS     = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam logic CMD_FILTER    = 1'b0;
  localparam logic CMD_TAP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

/* hdl/fircs_store.sv */
module fircs_store #(
  parameter int MAX_TAPS     = fircs_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = fircs_pkg::DEF_SAMPLE_WIDTH,
  parameter int AW           = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                                  clk,
  input  logic                                  tap_we,
  input  logic [AW-1:0]                         tap_waddr,
  input  logic signed [fircs_pkg::TAP_WIDTH-1:0] tap_wdata,
  input  logic [AW-1:0]                         tap_raddr,
  output logic signed [fircs_pkg::TAP_WIDTH-1:0] tap_q,
  input  logic                                  hist_we,
  input  logic [AW-1:0]                         hist_waddr,
  input  logic signed [SAMPLE_WIDTH-1:0]        hist_wdata_re,
  input  logic signed [SAMPLE_WIDTH-1:0]        hist_wdata_im,
  input  logic [AW-1:0]                         hist_raddr,
  output logic signed [SAMPLE_WIDTH-1:0]        hist_q_re,
  output logic signed [SAMPLE_WIDTH-1:0]        hist_q_im
);
  import fircs_pkg::*;

  logic [TAP_WIDTH-1:0]      tap_mem  [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0] hist_rd;

  // coefficient table, one write and one read port
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_q <= tap_mem[tap_raddr];
  end

  // sample history, real part in the upper half
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= {hist_wdata_re, hist_wdata_im};
    end
    hist_rd <= hist_mem[hist_raddr];
  end

  assign hist_q_re = hist_rd[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign hist_q_im = hist_rd[SAMPLE_WIDTH-1:0];

endmodule

/* hdl/fircs_mac.sv */
module fircs_mac #(
  parameter int SAMPLE_WIDTH = fircs_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fircs_pkg::mac_ctrl_t                   ctrl,
  output fircs_pkg::mac_stat_t                   stat,
  input  logic signed [fircs_pkg::TAP_WIDTH-1:0] tap_q,
  input  logic signed [SAMPLE_WIDTH-1:0]         hist_q_re,
  input  logic signed [SAMPLE_WIDTH-1:0]         hist_q_im,
  output logic signed [fircs_pkg::OUT_WIDTH-1:0] acc_re,
  output logic signed [fircs_pkg::OUT_WIDTH-1:0] acc_im
);
  import fircs_pkg::*;

  localparam int PW = TAP_WIDTH + SAMPLE_WIDTH;

  logic                 data_valid;
  logic                 prod_valid;
  logic signed [PW-1:0] prod_re;
  logic signed [PW-1:0] prod_im;

  // memory data lands in the cycle after the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      data_valid <= ctrl.issue;
      prod_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= tap_q * hist_q_re;
    prod_im <= tap_q * hist_q_im;
  end

  // sum wraps at the output width
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (prod_valid) begin
      acc_re <= acc_re + OUT_WIDTH'(prod_re);
      acc_im <= acc_im + OUT_WIDTH'(prod_im);
    end
  end

  assign stat.busy = data_valid | prod_valid;

endmodule

/* hdl/fir_filter_complex_stream.sv */
// direct-form fir filter, complex samples, real q1.15 taps
//
// input channel (in_valid / in_ready) carries one command per transaction:
//   command = filter: store sample_re/sample_im in the history and produce
//     one result, the exact sum of h(k)*x(n-k) over the active taps
//   command = tap write: store tap_value at tap_index, no result
// output channel (out_valid / out_ready) carries result_re / result_im,
// 38-bit signed sums scaled by 2^15
// num_taps is written through num_taps_wen / num_taps_wdata; the user must
// write it only while idle, the block itself does not enforce this
// one shared multiply-accumulate walks the taps, one tap per cycle, reading
// the coefficient and history memories in lockstep, over T taps, where T is
// the smaller of num_taps and the samples seen since start_of_signal (T = 0
// skips the walk and gives a zero result); with the output register free,
// in_ready returns with out_valid, so a filter transaction completes before
// the next is taken; a tap write leaves the block idle and gives no result
// after reset the block sweeps the tap memory to zero, one entry a cycle,
// with in_ready low; history needs no clearing
// a result waiting on out_ready does not block the next input transaction;
// the next result waits in the accumulator until the output register frees
module fir_filter_complex_stream #(
  parameter int MAX_TAPS     = fircs_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = fircs_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         command,
  input  logic                                         start_of_signal,
  input  logic signed [SAMPLE_WIDTH-1:0]               sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]               sample_im,
  input  logic [fircs_pkg::TAP_INDEX_WIDTH-1:0]        tap_index,
  input  logic signed [fircs_pkg::TAP_WIDTH-1:0]       tap_value,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [fircs_pkg::OUT_WIDTH-1:0]       result_re,
  output logic signed [fircs_pkg::OUT_WIDTH-1:0]       result_im,
  input  logic                                         num_taps_wen,
  input  logic [fircs_pkg::NUM_TAPS_WIDTH-1:0]         num_taps_wdata
);
  import fircs_pkg::*;

  // address width of the memories and width of a tap count (0..MAX_TAPS)
  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  state_t state;
  state_t state_next;

  logic [NUM_TAPS_WIDTH-1:0] num_taps;
  logic [AW-1:0]             wr_pos;
  logic [AW-1:0]             rd_ptr;
  logic [AW-1:0]             clr_addr;
  logic [CW-1:0]             vcount;
  logic [CW-1:0]             taps;
  logic [CW-1:0]             k;

  logic [CW-1:0] vcount_next;
  logic [CW-1:0] taps_cfg;
  logic [CW-1:0] taps_next;
  logic          filter_acc;
  logic          tap_acc;
  logic          out_free;
  logic          last_issue;
  logic          clr_last;

  logic                        tap_we;
  logic [AW-1:0]               tap_waddr;
  logic signed [TAP_WIDTH-1:0] tap_wdata;
  logic signed [TAP_WIDTH-1:0] tap_q;
  logic                        hist_we;
  logic signed [SAMPLE_WIDTH-1:0] hist_q_re;
  logic signed [SAMPLE_WIDTH-1:0] hist_q_im;

  mac_ctrl_t mac_ctrl;
  mac_stat_t mac_stat;
  logic signed [OUT_WIDTH-1:0] acc_re;
  logic signed [OUT_WIDTH-1:0] acc_im;

  // transaction decode
  assign filter_acc = in_valid && in_ready && (command == CMD_FILTER);
  assign tap_acc    = in_valid && in_ready && (command == CMD_TAP_WRITE);
  assign out_free   = !out_valid || out_ready;
  assign last_issue = (k == taps - CW'(1));
  assign clr_last   = (clr_addr == AW'(MAX_TAPS - 1));

  // valid sample count after this sample, saturating at the history depth
  always_comb begin
    if (start_of_signal) begin
      vcount_next = CW'(1);
    end else if (32'(vcount) < MAX_TAPS) begin
      vcount_next = vcount + CW'(1);
    end else begin
      vcount_next = vcount;
    end
  end

  // active taps: num_taps clamped to the depth, then to the valid history
  always_comb begin
    if (32'(num_taps) > MAX_TAPS) begin
      taps_cfg = CW'(MAX_TAPS);
    end else begin
      taps_cfg = CW'(num_taps);
    end
    taps_next = (taps_cfg > vcount_next) ? vcount_next : taps_cfg;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (filter_acc) begin
          state_next = (taps_next == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!mac_stat.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready       = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clear = 1'b0;
    case (state)
      ST_CLEAR: begin
        in_ready = 1'b0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // the accumulator restarts with each filter transaction
        mac_ctrl.clear = in_valid && (command == CMD_FILTER);
      end
      ST_RUN: begin
        mac_ctrl.issue = 1'b1;
      end
      ST_FLUSH: begin
        in_ready = 1'b0;
      end
      ST_DONE: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // tap memory write: zero sweep after reset, else tap-write transactions
  // (writes land only in idle, so they never race the tap walk)
  always_comb begin
    if (state == ST_CLEAR) begin
      tap_we    = 1'b1;
      tap_waddr = clr_addr;
      tap_wdata = '0;
    end else begin
      tap_we    = tap_acc && (32'(tap_index) < MAX_TAPS);
      tap_waddr = AW'(tap_index);
      tap_wdata = tap_value;
    end
  end

  // the new sample is written at acceptance and first read in the following cycle,
  // so the walk always sees it without forwarding
  assign hist_we = filter_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      num_taps  <= NUM_TAPS_WIDTH'(1);
      wr_pos    <= '0;
      clr_addr  <= '0;
      vcount    <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (num_taps_wen) begin
        num_taps <= num_taps_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (filter_acc) begin
        vcount <= vcount_next;
        k      <= '0;
        wr_pos <= (wr_pos == AW'(MAX_TAPS - 1)) ? '0 : wr_pos + AW'(1);
      end else if (state == ST_RUN) begin
        k <= k + CW'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (filter_acc) begin
      taps   <= taps_next;
      rd_ptr <= wr_pos;
    end else if (state == ST_RUN) begin
      // walk back through the history ring
      rd_ptr <= (rd_ptr == '0) ? AW'(MAX_TAPS - 1) : rd_ptr - AW'(1);
    end
    if (state == ST_DONE && out_free) begin
      result_re <= acc_re;
      result_im <= acc_im;
    end
  end

  fircs_store #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW)
  ) u_store (
    .clk           (clk),
    .tap_we        (tap_we),
    .tap_waddr     (tap_waddr),
    .tap_wdata     (tap_wdata),
    .tap_raddr     (AW'(k)),
    .tap_q         (tap_q),
    .hist_we       (hist_we),
    .hist_waddr    (wr_pos),
    .hist_wdata_re (sample_re),
    .hist_wdata_im (sample_im),
    .hist_raddr    (rd_ptr),
    .hist_q_re     (hist_q_re),
    .hist_q_im     (hist_q_im)
  );

  fircs_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .stat      (mac_stat),
    .tap_q     (tap_q),
    .hist_q_re (hist_q_re),
    .hist_q_im (hist_q_im),
    .acc_re    (acc_re),
    .acc_im    (acc_im)
  );

`include "fir_filter_complex_stream_assert.svh"

  // mac pipeline must be drained before a new transaction is taken
  `FIRCS_ASSERT_NOW(a_idle_drained, clk, rst, state == ST_IDLE, !mac_stat.busy, "mac busy in idle")
  // reads are issued only for active taps
  `FIRCS_ASSERT_NOW(a_issue_in_range, clk, rst, mac_ctrl.issue, k < taps, "tap walk overran")
  // a new result only comes from the done state
  `FIRCS_ASSERT_NOW(a_result_from_done, clk, rst, $rose(out_valid), $past(state == ST_DONE), "stray result")
  // a filter transaction with active taps starts the walk
  `FIRCS_ASSERT_NEXT(a_walk_starts, clk, rst, filter_acc && (taps_next != '0), state == ST_RUN, "walk missing")

endmodule
